@@ rtl/core/piecewise_affine_warp_map_top_macros.svh @@
// Assertion macros used by the warp map checker.
`ifndef PIECEWISE_AFFINE_WARP_MAP_TOP_MACROS_SVH
`define PIECEWISE_AFFINE_WARP_MAP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WMAP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wmap check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WMAP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wmap check failed");

`endif

@@ rtl/core/wmap_pkg.sv @@
// Types and constants of the warp map block.
`default_nettype none
package wmap_pkg;
	localparam int MaxTriangles  = 128;
	localparam int MaxRegionSide = 4096;

	localparam int TriW     = 7;
	localparam int PixW     = 12;
	localparam int ValW     = 32;
	localparam int NumVal   = 6;
	localparam int CoefW    = 48;
	localparam int CoefLoW  = CoefW / 2;
	localparam int CoordW   = 24;
	localparam int OffW     = 24;
	localparam int UW       = CoordW + 2;
	localparam int TriAddrW = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1;

	localparam int ValLsb   = TriW + 1 + 2 * PixW;
	localparam int WtRowW   = NumVal * ValW;
	localparam int CoefRowW = NumVal * CoefW;
	localparam int InDataW  = ValLsb + WtRowW;
	localparam int InUserW  = 2;
	localparam int OutDataW = 2 * CoordW;

	localparam int CfgAddrW = 1;
	localparam int CfgDataW = OffW;
	localparam logic [CfgAddrW-1:0] RegOffsetX = 1'b0;
	localparam logic [CfgAddrW-1:0] RegOffsetY = 1'b1;

	localparam int OpAW  = 34;
	localparam int OpBW  = 33;
	localparam int ProdW = OpAW + OpBW;
	localparam int AccW  = 76;

	localparam int BaseShift       = 24;
	localparam int ShapeFracShift  = 8;
	localparam int ShapeRound      = 1 << (ShapeFracShift - 1);
	localparam int PixBaseShift    = 8;
	localparam int PixHiShift      = 24;
	localparam int PixFracShift    = 24;
	localparam int PixRound        = 1 << (PixFracShift - 1);

	localparam int StepW = 4;
	localparam logic [StepW-1:0] ShapeLastStep = 4'd11;
	localparam logic [StepW-1:0] PixelLastStep = 4'd7;

	localparam logic signed [CoordW-1:0] OutsideCoord = -24'sd256;

	typedef enum logic [1:0] {
		ACT_LOAD_WEIGHTS = 2'd0,
		ACT_LOAD_SHAPE   = 2'd1,
		ACT_MAP_PIXEL    = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef enum logic {
		MODE_SHAPE,
		MODE_PIXEL
	} mode_t;

	typedef struct packed {
		logic                   we;
		logic                   re;
		logic [TriAddrW-1:0]    waddr;
		logic [TriAddrW-1:0]    raddr;
	} ram_ctl_t;

	typedef struct packed {
		logic                   vld;
		logic                   first;
		logic                   last;
		logic                   shift;
		mode_t                  mode;
		logic [2:0]             idx;
		logic signed [OpAW-1:0] op_a;
		logic signed [OpBW-1:0] op_b;
		logic signed [AccW-1:0] init;
	} mac_op_t;

	typedef struct packed {
		logic                             busy;
		logic [NumVal-1:0][CoefW-1:0]     coef;
		logic [CoordW-1:0]                px;
		logic [CoordW-1:0]                py;
	} mac_res_t;
endpackage
`default_nettype wire

@@ rtl/core/wmap_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module wmap_ram #(
	parameter int Width = 32,
	parameter int Depth = 128
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  wire logic [Width-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic      [Width-1:0]                       rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/wmap_mac.sv @@
// Shared multiplier, accumulator and round/saturate stage.
`default_nettype none
module wmap_mac import wmap_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_op_t  op,
	output mac_res_t      res
);
	logic                          vld_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic                          shift_s1;
	mode_t                         mode_s1;
	logic [2:0]                    idx_s1;
	logic signed [ProdW-1:0]       prod_s1;
	logic signed [AccW-1:0]        init_s1;
	logic signed [AccW-1:0]        acc_q;
	logic signed [AccW-1:0]        term;
	logic signed [AccW-1:0]        acc_d;
	logic                          fin_s2;
	mode_t                         mode_s2;
	logic [2:0]                    idx_s2;
	logic signed [AccW-1:0]        shape_sh;
	logic signed [AccW-1:0]        pix_sh;
	logic [CoefW-1:0]              coef_sat;
	logic [CoordW-1:0]             pix_sat;
	logic [NumVal-1:0][CoefW-1:0]  coef_q;
	logic [CoordW-1:0]             px_q;
	logic [CoordW-1:0]             py_q;

	always_comb begin
		term     = shift_s1 ? (AccW'(prod_s1) <<< PixHiShift) : AccW'(prod_s1);
		acc_d    = (first_s1 ? init_s1 : acc_q) + term;
		shape_sh = acc_q >>> ShapeFracShift;
		pix_sh   = acc_q >>> PixFracShift;
		if ((&shape_sh[AccW-1:CoefW-1]) || !(|shape_sh[AccW-1:CoefW-1])) begin
			coef_sat = shape_sh[CoefW-1:0];
		end else if (shape_sh[AccW-1]) begin
			coef_sat = {1'b1, {(CoefW-1){1'b0}}};
		end else begin
			coef_sat = {1'b0, {(CoefW-1){1'b1}}};
		end
		if ((&pix_sh[AccW-1:CoordW-1]) || !(|pix_sh[AccW-1:CoordW-1])) begin
			pix_sat = pix_sh[CoordW-1:0];
		end else if (pix_sh[AccW-1]) begin
			pix_sat = {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			pix_sat = {1'b0, {(CoordW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fin_s2 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
			fin_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= op.first;
		last_s1  <= op.last;
		shift_s1 <= op.shift;
		mode_s1  <= op.mode;
		idx_s1   <= op.idx;
		prod_s1  <= $signed(op.op_a) * $signed(op.op_b);
		init_s1  <= op.init;
		mode_s2  <= mode_s1;
		idx_s2   <= idx_s1;
		if (vld_s1) begin
			acc_q <= acc_d;
		end
		if (fin_s2) begin
			if (mode_s2 == MODE_SHAPE) begin
				coef_q[idx_s2] <= coef_sat;
			end else if (idx_s2[0]) begin
				py_q <= pix_sat;
			end else begin
				px_q <= pix_sat;
			end
		end
	end

	assign res.busy = vld_s1 | fin_s2;
	assign res.coef = coef_q;
	assign res.px   = px_q;
	assign res.py   = py_q;
endmodule
`default_nettype wire

@@ rtl/core/wmap_ctrl.sv @@
// Sequencer: stream handshake, table access and operand selection.
`default_nettype none
module wmap_ctrl import wmap_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [InDataW-1:0]            s_tdata,
	input  wire logic [InUserW-1:0]            s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [OutDataW-1:0]                m_tdata,
	output logic                               m_tuser,
	input  wire logic [OffW-1:0]               off_x,
	input  wire logic [OffW-1:0]               off_y,
	output ram_ctl_t                           wt_ctl,
	output logic [WtRowW-1:0]                  wt_wdata,
	input  wire logic [NumVal-1:0][ValW-1:0]   wt_rdata,
	output ram_ctl_t                           coef_ctl,
	input  wire logic [NumVal-1:0][CoefW-1:0]  coef_rdata,
	output mac_op_t                            op,
	input  wire mac_res_t                      res
);
	state_t                         state_q;
	state_t                         state_d;
	logic [StepW-1:0]               step_q;
	mode_t                          mode_q;
	logic                           outside_q;
	logic [TriW-1:0]                tri_q;
	logic [PixW-1:0]                col_q;
	logic [PixW-1:0]                row_q;
	logic [NumVal-1:0][ValW-1:0]    val_q;
	logic signed [ValW:0]           diff_q [4];
	logic                           m_tvalid_q;
	logic [OutDataW-1:0]            m_tdata_q;
	logic                           m_tuser_q;

	logic                           accept;
	action_t                        act_in;
	logic [TriW-1:0]                tri_in;
	logic                           inside_in;
	logic [PixW-1:0]                col_in;
	logic [PixW-1:0]                row_in;
	logic                           tri_ok;
	logic                           pix_out;
	logic                           out_load;
	logic signed [UW-1:0]           u_val;
	logic signed [UW-1:0]           v_val;
	logic [2:0]                     grp_sh;
	logic                           ax;
	logic [2:0]                     k3;
	logic [2:0]                     widx;
	logic [2:0]                     cbase;
	logic [2:0]                     ck;
	logic [CoefW-1:0]               csel;
	logic signed [ValW-1:0]         base;
	logic [StepW-1:0]               last_step;

	assign accept    = s_tvalid && s_tready;
	assign act_in    = action_t'(s_tuser);
	assign tri_in    = s_tdata[TriW-1:0];
	assign inside_in = s_tdata[TriW];
	assign col_in    = s_tdata[TriW+1 +: PixW];
	assign row_in    = s_tdata[TriW+1+PixW +: PixW];
	assign wt_wdata  = s_tdata[ValLsb +: WtRowW];
	assign tri_ok    = 32'(tri_in) < MaxTriangles;
	assign pix_out   = !inside_in || !tri_ok || (32'(col_in) >= MaxRegionSide)
		|| (32'(row_in) >= MaxRegionSide);
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign last_step = (mode_q == MODE_SHAPE) ? ShapeLastStep : PixelLastStep;

	assign u_val = $signed({{(UW-PixW-8){1'b0}}, col_q, 8'b0}) + UW'($signed(off_x));
	assign v_val = $signed({{(UW-PixW-8){1'b0}}, row_q, 8'b0}) + UW'($signed(off_y));

	always_comb begin
		wt_ctl.we      = accept && (act_in == ACT_LOAD_WEIGHTS) && tri_ok;
		wt_ctl.re      = accept && (act_in == ACT_LOAD_SHAPE) && tri_ok;
		wt_ctl.waddr   = TriAddrW'(tri_in);
		wt_ctl.raddr   = TriAddrW'(tri_in);
		coef_ctl.we    = (state_q == ST_DRAIN) && !res.busy && (mode_q == MODE_SHAPE);
		coef_ctl.re    = accept && (act_in == ACT_MAP_PIXEL) && !pix_out;
		coef_ctl.waddr = TriAddrW'(tri_q);
		coef_ctl.raddr = TriAddrW'(tri_in);
	end

	always_comb begin
		grp_sh = step_q[3:1];
		ax     = grp_sh >= 3'd3;
		k3     = ax ? (grp_sh - 3'd3) : grp_sh;
		widx   = step_q[0] ? (k3 + 3'd3) : k3;
		cbase  = step_q[2] ? 3'd3 : 3'd0;
		ck     = cbase + (step_q[1] ? 3'd2 : 3'd1);
		csel   = coef_rdata[ck];
		if (grp_sh == 3'd0) begin
			base = $signed(val_q[0]);
		end else if (grp_sh == 3'd3) begin
			base = $signed(val_q[3]);
		end else begin
			base = '0;
		end
		op.vld  = state_q == ST_RUN;
		op.mode = mode_q;
		if (mode_q == MODE_SHAPE) begin
			op.first = !step_q[0];
			op.last  = step_q[0];
			op.shift = 1'b0;
			op.idx   = grp_sh;
			op.op_a  = OpAW'(diff_q[{ax, step_q[0]}]);
			op.op_b  = OpBW'($signed(wt_rdata[widx]));
			op.init  = (AccW'(base) <<< BaseShift) + AccW'(ShapeRound);
		end else begin
			op.first = step_q[1:0] == 2'd0;
			op.last  = step_q[1:0] == 2'd3;
			op.shift = step_q[0];
			op.idx   = {2'b0, step_q[2]};
			op.op_a  = step_q[0] ? OpAW'($signed(csel[CoefW-1:CoefLoW]))
				: $signed(OpAW'(csel[CoefLoW-1:0]));
			op.op_b  = step_q[1] ? OpBW'(v_val) : OpBW'(u_val);
			op.init  = (AccW'($signed(coef_rdata[cbase])) <<< PixBaseShift)
				+ AccW'(PixRound);
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (act_in)
						ACT_LOAD_SHAPE: begin
							if (tri_ok) begin
								state_d = ST_LOAD;
							end
						end
						ACT_MAP_PIXEL: begin
							state_d = pix_out ? ST_OUT : ST_LOAD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LOAD: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == last_step) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!res.busy) begin
					state_d = (mode_q == MODE_SHAPE) ? ST_IDLE : ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_RUN) begin
				step_q <= step_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q     <= tri_in;
			col_q     <= col_in;
			row_q     <= row_in;
			val_q     <= s_tdata[ValLsb +: WtRowW];
			mode_q    <= (act_in == ACT_MAP_PIXEL) ? MODE_PIXEL : MODE_SHAPE;
			outside_q <= pix_out;
		end
		if (state_q == ST_LOAD) begin
			diff_q[0] <= (ValW+1)'($signed(val_q[1])) - (ValW+1)'($signed(val_q[0]));
			diff_q[1] <= (ValW+1)'($signed(val_q[2])) - (ValW+1)'($signed(val_q[0]));
			diff_q[2] <= (ValW+1)'($signed(val_q[4])) - (ValW+1)'($signed(val_q[3]));
			diff_q[3] <= (ValW+1)'($signed(val_q[5])) - (ValW+1)'($signed(val_q[3]));
		end
		if (out_load) begin
			m_tdata_q <= outside_q ? {OutsideCoord, OutsideCoord} : {res.py, res.px};
			m_tuser_q <= outside_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule
`default_nettype wire

@@ rtl/core/piecewise_affine_warp_map_top.sv @@
// Top level of the piecewise affine warp map block.
// Usage:
//  Input stream s_*: tuser carries the action (load weights, load shape, map
//  pixel); tdata carries triangle, mask bit, column, row and six 32-bit values.
//  Output stream m_*: one transaction per map-pixel item, source x/y in tdata,
//  the outside flag in tuser. Loads produce no output.
//  Config port: cfg_we/cfg_addr/cfg_wdata set offset_x (0) and offset_y (1);
//  write only while the block is idle.
// Sequence: items are accepted only while idle. Load weights writes the
//  weights table and stays idle; load shape and inside pixel read a table.
//  One 34x33 multiplier is shared by all products: 12 per shape, 8 per pixel,
//  which follow the table read, then an accumulate/round drain and, for a
//  pixel, the output stage. A shape writes its coefficients to the
//  coefficient table at the end of its drain. An outside pixel skips the
//  table read and the multiplier and goes straight to the output stage.
// Reset: offsets clear to zero; the triangle tables are not cleared and must be
//  loaded before use. When the receiver stalls, the result is held in the
//  output register and the next item is still accepted; a following pixel
//  waits at its end until the output register frees up.
`default_nettype none
module piecewise_affine_warp_map_top import wmap_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// triangle_index, inside_req, pixel_col, pixel_row, value_0 .. value_5
	input  wire logic [InDataW-1:0]   s_tdata,
	// action
	input  wire logic [InUserW-1:0]   s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// source_x, source_y
	output logic [OutDataW-1:0]       m_tdata,
	// outside
	output logic                      m_tuser,
	input  wire logic                 cfg_we,
	input  wire logic [CfgAddrW-1:0]  cfg_addr,
	input  wire logic [CfgDataW-1:0]  cfg_wdata
);
	logic [OffW-1:0]               off_x_q;
	logic [OffW-1:0]               off_y_q;
	ram_ctl_t                      wt_ctl;
	ram_ctl_t                      coef_ctl;
	logic [WtRowW-1:0]             wt_wdata;
	logic [NumVal-1:0][ValW-1:0]   wt_rdata;
	logic [NumVal-1:0][CoefW-1:0]  coef_rdata;
	mac_op_t                       op;
	mac_res_t                      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				RegOffsetX: off_x_q <= cfg_wdata;
				RegOffsetY: off_y_q <= cfg_wdata;
				default: begin
					off_x_q <= off_x_q;
				end
			endcase
		end
	end

	wmap_ram #(
		.Width (WtRowW),
		.Depth (MaxTriangles)
	) u_wt_ram (
		.clk   (clk),
		.we    (wt_ctl.we),
		.waddr (wt_ctl.waddr),
		.wdata (wt_wdata),
		.re    (wt_ctl.re),
		.raddr (wt_ctl.raddr),
		.rdata (wt_rdata)
	);

	wmap_ram #(
		.Width (CoefRowW),
		.Depth (MaxTriangles)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_ctl.we),
		.waddr (coef_ctl.waddr),
		.wdata (res.coef),
		.re    (coef_ctl.re),
		.raddr (coef_ctl.raddr),
		.rdata (coef_rdata)
	);

	wmap_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.off_x      (off_x_q),
		.off_y      (off_y_q),
		.wt_ctl     (wt_ctl),
		.wt_wdata   (wt_wdata),
		.wt_rdata   (wt_rdata),
		.coef_ctl   (coef_ctl),
		.coef_rdata (coef_rdata),
		.op         (op),
		.res        (res)
	);

	wmap_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res)
	);
endmodule
`default_nettype wire

@@ rtl/core/wmap_chk.sv @@
// Port-level checker for the warp map top level, with its bind.
`default_nettype none
`include "piecewise_affine_warp_map_top_macros.svh"
module wmap_chk import wmap_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [InUserW-1:0]   s_tuser,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [OutDataW-1:0]  m_tdata,
	input wire logic                 m_tuser
);
	`WMAP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`WMAP_ASSERT_SAME(a_outside_coord, m_tvalid && m_tuser, (m_tdata[CoordW-1:0] == OutsideCoord) && (m_tdata[OutDataW-1:CoordW] == OutsideCoord))
	`WMAP_ASSERT_NEXT(a_pixel_busy, s_tvalid && s_tready && (s_tuser == ACT_MAP_PIXEL), !s_tready)
	`WMAP_ASSERT_NEXT(a_weights_ready, s_tvalid && s_tready && (s_tuser == ACT_LOAD_WEIGHTS), s_tready)
endmodule

bind piecewise_affine_warp_map_top wmap_chk u_wmap_chk (.*);
`default_nettype wire
